FILE: sv/tff_pkg.sv
// shared constants, word types and controller/datapath interface structs
// for the threshold flood fill unit; no dependencies
package tff_pkg;

  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 256;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int RCNT_W   = ROW_W + 1;
  localparam int CCNT_W   = COL_W + 1;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int QPTR_W   = ADDR_W + 1;
  localparam int QWORD_W  = ROW_W + COL_W;
  localparam int CNT_W    = 17;

  localparam logic [7:0] THR_RESET  = 8'd125;
  localparam logic [8:0] DIM_RESET  = 9'd256;
  localparam logic [7:0] FULL_PIX   = 8'd255;
  localparam logic [CNT_W-1:0] CNT_LIMIT = {CNT_W{1'b1}};

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_FILL = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_ROWS      = 2'd1;
  localparam logic [1:0] REG_COLS      = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] pixel_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0]       pixel_out;
    logic [CNT_W-1:0] filled_count;
    logic             is_fill_result;
  } out_word_t;

  typedef struct packed {
    logic load_pix;
    logic rd_issue;
    logic rd_done;
    logic fill_start;
    logic pop;
    logic take;
    logic nb_issue;
    logic nb_eval;
    logic fill_done;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic q_busy;
    logic nb_last;
  } dp_stat_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    cell_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c));
  endfunction

endpackage

FILE: sv/tff_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module tff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/tff_ctrl.sv
// sequencer for load, read and breadth-first fill commands
// depends on tff_pkg
module tff_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_command,
  output logic              in_stall,
  input  tff_pkg::dp_stat_t stat,
  output tff_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_POP, S_QWAIT, S_NB_RD, S_NB_EV
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE) || stat.out_busy;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_command)
            tff_pkg::CMD_LOAD: cmd.load_pix = 1'b1;
            tff_pkg::CMD_READ: begin
              cmd.rd_issue = 1'b1;
              state_nxt    = S_RD;
            end
            tff_pkg::CMD_FILL: begin
              cmd.fill_start = 1'b1;
              state_nxt      = S_POP;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        cmd.rd_done = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_POP: begin
        if (stat.q_busy) begin
          cmd.pop   = 1'b1;
          state_nxt = S_QWAIT;
        end else begin
          cmd.fill_done = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_QWAIT: begin
        cmd.take  = 1'b1;
        state_nxt = S_NB_RD;
      end
      S_NB_RD: begin
        cmd.nb_issue = 1'b1;
        state_nxt    = S_NB_EV;
      end
      S_NB_EV: begin
        cmd.nb_eval = 1'b1;
        state_nxt   = stat.nb_last ? S_POP : S_NB_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/tff_dp.sv
// datapath: image store, pending queue, neighbor walk and result register
// depends on tff_pkg and tff_ram
module tff_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tff_pkg::dp_cmd_t           cmd,
  output tff_pkg::dp_stat_t          stat,
  input  tff_pkg::in_word_t          in_word,
  input  logic [7:0]                 threshold,
  input  logic [tff_pkg::RCNT_W-1:0] eff_rows,
  input  logic [tff_pkg::CCNT_W-1:0] eff_cols,
  output logic                       out_valid,
  input  logic                       out_stall,
  output tff_pkg::out_word_t         out_word
);

  logic [tff_pkg::ROW_W-1:0]   row_r, nb_row_r;
  logic [tff_pkg::COL_W-1:0]   col_r, nb_col_r;
  logic                        inside_r, nb_ok_r, nb_hit;
  logic [tff_pkg::QPTR_W-1:0]  head_r, tail_r;
  logic [tff_pkg::CNT_W-1:0]   count_r;
  logic [1:0]                  dr_r, dc_r;
  logic [tff_pkg::ADDR_W-1:0]  nb_addr_r, nb_addr_c, in_addr;
  logic                        out_valid_r;
  tff_pkg::out_word_t          out_word_r;
  logic                        in_inside, nb_ok_c, q_room;
  logic [tff_pkg::ROW_W+1:0]   nr_s;
  logic [tff_pkg::COL_W+1:0]   nc_s;

  logic                        img_we;
  logic [tff_pkg::ADDR_W-1:0]  img_waddr, img_raddr;
  logic [7:0]                  img_wdata, img_rdata;
  logic                        q_we;
  logic [tff_pkg::ADDR_W-1:0]  q_waddr;
  logic [tff_pkg::QWORD_W-1:0] q_wdata, q_rdata;

  assign in_inside = (32'(in_word.row) < 32'(eff_rows)) && (32'(in_word.col) < 32'(eff_cols));
  assign in_addr   = tff_pkg::cell_addr(tff_pkg::ROW_W'(in_word.row),
                                        tff_pkg::COL_W'(in_word.col));

  // neighbor offset is dr-1, dc-1; a negative coordinate shows in the top bit
  assign nr_s = (tff_pkg::ROW_W+2)'(row_r) + (tff_pkg::ROW_W+2)'(dr_r) - 1'b1;
  assign nc_s = (tff_pkg::COL_W+2)'(col_r) + (tff_pkg::COL_W+2)'(dc_r) - 1'b1;
  assign nb_ok_c = !nr_s[tff_pkg::ROW_W+1] && !nc_s[tff_pkg::COL_W+1]
                && (nr_s < (tff_pkg::ROW_W+2)'(eff_rows))
                && (nc_s < (tff_pkg::COL_W+2)'(eff_cols));
  assign nb_addr_c = tff_pkg::cell_addr(nr_s[tff_pkg::ROW_W-1:0], nc_s[tff_pkg::COL_W-1:0]);

  // a filled pixel becomes 255, which never passes the threshold again
  assign nb_hit = nb_ok_r && (img_rdata < threshold);
  assign q_room = tail_r < tff_pkg::QPTR_W'(tff_pkg::CELLS);

  assign img_we    = (cmd.load_pix && in_inside) || (cmd.nb_eval && nb_hit);
  assign img_waddr = cmd.load_pix ? in_addr : nb_addr_r;
  assign img_wdata = cmd.load_pix ? in_word.pixel_value : tff_pkg::FULL_PIX;
  assign img_raddr = cmd.nb_issue ? nb_addr_c : in_addr;

  assign q_we    = (cmd.fill_start && in_inside) || (cmd.nb_eval && nb_hit && q_room);
  assign q_waddr = cmd.fill_start ? '0 : tail_r[tff_pkg::ADDR_W-1:0];
  assign q_wdata = cmd.fill_start
                 ? {tff_pkg::ROW_W'(in_word.row), tff_pkg::COL_W'(in_word.col)}
                 : {nb_row_r, nb_col_r};

  tff_ram #(.WIDTH(8), .DEPTH(tff_pkg::CELLS)) u_img (
    .clk(clk), .we(img_we), .waddr(img_waddr), .wdata(img_wdata),
    .raddr(img_raddr), .rdata(img_rdata)
  );

  tff_ram #(.WIDTH(tff_pkg::QWORD_W), .DEPTH(tff_pkg::CELLS)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(head_r[tff_pkg::ADDR_W-1:0]), .rdata(q_rdata)
  );

  assign stat.out_busy = out_valid_r && out_stall;
  assign stat.q_busy   = (head_r != tail_r) && (head_r < tff_pkg::QPTR_W'(tff_pkg::CELLS));
  assign stat.nb_last  = (dr_r == 2'd2) && (dc_r == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      dr_r        <= '0;
      dc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.rd_issue) begin
        inside_r <= in_inside;
      end
      if (cmd.fill_start) begin
        head_r  <= '0;
        tail_r  <= in_inside ? tff_pkg::QPTR_W'(1) : '0;
        count_r <= '0;
      end
      if (cmd.pop) begin
        head_r <= head_r + 1'b1;
      end
      if (cmd.take) begin
        row_r <= q_rdata[tff_pkg::QWORD_W-1:tff_pkg::COL_W];
        col_r <= q_rdata[tff_pkg::COL_W-1:0];
        dr_r  <= '0;
        dc_r  <= '0;
      end
      if (cmd.nb_issue) begin
        nb_ok_r   <= nb_ok_c;
        nb_addr_r <= nb_addr_c;
        nb_row_r  <= nr_s[tff_pkg::ROW_W-1:0];
        nb_col_r  <= nc_s[tff_pkg::COL_W-1:0];
      end
      if (cmd.nb_eval) begin
        if (dc_r == 2'd2) begin
          dc_r <= '0;
          dr_r <= dr_r + 1'b1;
        end else begin
          dc_r <= dc_r + 1'b1;
        end
        if (nb_hit) begin
          if (q_room) begin
            tail_r <= tail_r + 1'b1;
          end
          if (count_r != tff_pkg::CNT_LIMIT) begin
            count_r <= count_r + 1'b1;
          end
        end
      end
      if (cmd.rd_done) begin
        out_valid_r <= 1'b1;
        out_word_r  <= '{pixel_out: inside_r ? img_rdata : 8'd0,
                         filled_count: '0, is_fill_result: 1'b0};
      end
      if (cmd.fill_done) begin
        out_valid_r <= 1'b1;
        out_word_r  <= '{pixel_out: 8'd0, filled_count: count_r, is_fill_result: 1'b1};
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef ASSERT_OFF
  a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n) head_r <= tail_r)
    else $error("queue head passed tail");
  a_rd_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_done |=> out_valid_r && !out_word_r.is_fill_result)
    else $error("read did not yield a read result");
  a_fill_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill_done |=> out_valid_r && out_word_r.is_fill_result
                      && out_word_r.filled_count == $past(count_r))
    else $error("fill result lost its count");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_done || cmd.fill_done) |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while held");
`endif

endmodule

FILE: sv/threshold_flood_fill_unit.sv
// load: one per cycle while not stalled; read: registered image ram read, then the result register
// fill: per dequeued pixel a pop, a take, then a read and an evaluate per cell of its 3x3 window
// the fill rate is set by the single read port of the image ram
// a new word is taken while idle and the result register is free or being emptied
// rst_n is synchronous, active low: registers reset, image contents undefined
// top level: apb registers, controller and datapath; depends on tff_pkg
module threshold_flood_fill_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tff_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output tff_pkg::out_word_t out_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0]                 threshold_r;
  logic [8:0]                 rows_r, cols_r;
  logic [tff_pkg::RCNT_W-1:0] eff_rows;
  logic [tff_pkg::CCNT_W-1:0] eff_cols;
  logic                       wr_en;
  tff_pkg::dp_cmd_t           cmd;
  tff_pkg::dp_stat_t          stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= tff_pkg::THR_RESET;
      rows_r      <= tff_pkg::DIM_RESET;
      cols_r      <= tff_pkg::DIM_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        tff_pkg::REG_THRESHOLD: threshold_r <= pwdata[7:0];
        tff_pkg::REG_ROWS:      rows_r      <= pwdata[8:0];
        tff_pkg::REG_COLS:      cols_r      <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      tff_pkg::REG_THRESHOLD: prdata = 32'(threshold_r);
      tff_pkg::REG_ROWS:      prdata = 32'(rows_r);
      tff_pkg::REG_COLS:      prdata = 32'(cols_r);
      default:                prdata = '0;
    endcase
  end

  assign eff_rows = (32'(rows_r) > tff_pkg::MAX_ROWS) ? tff_pkg::RCNT_W'(tff_pkg::MAX_ROWS)
                                                      : tff_pkg::RCNT_W'(rows_r);
  assign eff_cols = (32'(cols_r) > tff_pkg::MAX_COLS) ? tff_pkg::CCNT_W'(tff_pkg::MAX_COLS)
                                                      : tff_pkg::CCNT_W'(cols_r);

  tff_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_command(in_word.command),
    .in_stall(in_stall), .stat(stat), .cmd(cmd)
  );

  tff_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_word(in_word),
    .threshold(threshold_r), .eff_rows(eff_rows), .eff_cols(eff_cols),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

endmodule
